// ----- design/pwmscan_pkg.sv -----
package pwmscan_pkg;

   localparam int MAX_MOTIF_LEN_DEF = 32;
   localparam int WEIGHT_BITS_DEF   = 16;
   localparam int POS_BITS_DEF      = 16;

   localparam int SCORE_W   = 21;
   localparam int HIT_POS_W = 16;
   localparam int SCORE_MAX = 1048575;
   localparam int SCORE_MIN = -1048576;

   typedef logic [2:0] base_code_type;

   localparam base_code_type CODE_A    = 3'd0;
   localparam base_code_type CODE_C    = 3'd1;
   localparam base_code_type CODE_G    = 3'd2;
   localparam base_code_type CODE_T    = 3'd3;
   localparam base_code_type CODE_NONE = 3'd4;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;

   localparam logic KIND_WEIGHT = 1'b0;
   localparam logic KIND_CHAR   = 1'b1;

   localparam logic CSR_MOTIF_LENGTH  = 1'b0;
   localparam logic CSR_HIT_THRESHOLD = 1'b1;

   // control for one base cell of the window ring
   typedef struct packed {
      logic advance;
      logic clear;
   } cell_ctl_type;

   // control for the weight store and score accumulator
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } score_ctl_type;

   function automatic base_code_type base_code(input logic [7:0] ch);
      base_code_type code;
      unique case (ch)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

// ----- design/pwm_motif_window_scanner.sv -----
// Position weight matrix scanner for DNA text. Weight items (kind 0) load one
// signed Q7.8 entry of the 4 x MAX_MOTIF_LEN table. A character item shifts its
// base into the window ring; if the sequence does not yet hold motif_length
// bases no window is scored, otherwise the block stalls requests through a
// sweep, a flush and a finish step: the ring of base cells rotates once past a
// single tap, at most one weight is read from the table per step, then the
// flush step waits for the last read and the finish step compares and posts the
// hit. A hit waits in the output register; if that register is still full when
// the next hit is ready, the block holds until it is taken. Hits carry the
// 1-based window start (65535 once the position counter saturates) and the score
// saturated to 21 bits, while the threshold compare uses the full sum.
module pwm_motif_window_scanner #(
   parameter int MAX_MOTIF_LEN = pwmscan_pkg::MAX_MOTIF_LEN_DEF,
   parameter int WEIGHT_BITS   = pwmscan_pkg::WEIGHT_BITS_DEF,
   parameter int POS_BITS      = pwmscan_pkg::POS_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [4:0]                            req_weight_offset,
   input  logic [1:0]                            req_weight_base,
   input  logic signed [15:0]                    req_weight_value,
   input  logic [7:0]                            req_seq_char,
   input  logic                                  req_seq_start,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pwmscan_pkg::HIT_POS_W-1:0]     rsp_hit_position,
   output logic signed [pwmscan_pkg::SCORE_W-1:0] rsp_hit_score,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [pwmscan_pkg::SCORE_W-1:0]       csr_write_data
);

   localparam int OFF_W  = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
   localparam int ADDR_W = OFF_W + 2;
   localparam int LEN_W  = $clog2(MAX_MOTIF_LEN + 1);
   localparam int SUM_W  = WEIGHT_BITS + LEN_W;
   localparam int CMP_W  = (SUM_W > pwmscan_pkg::SCORE_W) ? SUM_W : pwmscan_pkg::SCORE_W;

   localparam logic [OFF_W-1:0]    STEP_LAST = OFF_W'(MAX_MOTIF_LEN - 1);
   localparam logic [POS_BITS-1:0] POS_MAX   = '1;
   localparam logic signed [32:0]  W_MAX     = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0]  W_MIN     = -W_MAX - 33'sd1;
   localparam logic signed [CMP_W-1:0] S_MAX = CMP_W'(pwmscan_pkg::SCORE_MAX);
   localparam logic signed [CMP_W-1:0] S_MIN = CMP_W'(pwmscan_pkg::SCORE_MIN);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_FLUSH  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [OFF_W-1:0]           step_ff, step_in;
   logic [5:0]                 motif_length_ff;
   logic signed [pwmscan_pkg::SCORE_W-1:0] threshold_ff;
   logic [POS_BITS-1:0]        chars_seen_ff, chars_seen_in;
   logic [pwmscan_pkg::HIT_POS_W-1:0] pos_ff, pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pwmscan_pkg::HIT_POS_W-1:0] rsp_pos_ff;
   logic signed [pwmscan_pkg::SCORE_W-1:0] rsp_score_ff;

   logic                       req_accept, char_accept, weight_accept;
   logic                       rsp_take, rsp_load;
   logic [LEN_W-1:0]           act_len;
   logic [POS_BITS-1:0]        pos_calc;
   logic                       window_full;
   logic                       in_window;
   logic [OFF_W-1:0]           rd_offset;
   logic signed [32:0]         weight_wide, weight_clamped;
   logic signed [WEIGHT_BITS-1:0] weight_sat;
   logic signed [SUM_W-1:0]    score;
   logic signed [CMP_W-1:0]    score_wide, threshold_wide, score_sat;
   logic                       hit;

   pwmscan_pkg::base_code_type new_code;
   pwmscan_pkg::base_code_type ring [MAX_MOTIF_LEN];
   pwmscan_pkg::base_code_type tap;
   pwmscan_pkg::score_ctl_type score_ctl;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign char_accept   = req_accept && (req_kind == pwmscan_pkg::KIND_CHAR);
   assign weight_accept = req_accept && (req_kind == pwmscan_pkg::KIND_WEIGHT);
   assign rsp_take      = rsp_valid_ff && !rsp_stall;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         motif_length_ff <= 6'd32;
         threshold_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            pwmscan_pkg::CSR_MOTIF_LENGTH:  motif_length_ff <= csr_write_data[5:0];
            pwmscan_pkg::CSR_HIT_THRESHOLD: threshold_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (motif_length_ff == '0) begin
         act_len = LEN_W'(1);
      end else if (32'(motif_length_ff) > 32'(MAX_MOTIF_LEN)) begin
         act_len = LEN_W'(MAX_MOTIF_LEN);
      end else begin
         act_len = LEN_W'(motif_length_ff);
      end
   end

   // position counter for the current sequence
   always_comb begin
      if (req_seq_start) begin
         chars_seen_in = POS_BITS'(1);
      end else if (chars_seen_ff == POS_MAX) begin
         chars_seen_in = chars_seen_ff;
      end else begin
         chars_seen_in = chars_seen_ff + 1'b1;
      end
      window_full = 33'(chars_seen_in) >= 33'(act_len);
      pos_calc    = chars_seen_in - POS_BITS'(act_len) + 1'b1;
      if (chars_seen_in == POS_MAX || 33'(pos_calc) > 33'(16'hFFFF)) begin
         pos_in = 16'hFFFF;
      end else begin
         pos_in = 16'(pos_calc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_seen_ff <= '0;
      end else if (char_accept) begin
         chars_seen_ff <= chars_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (char_accept) begin
         pos_ff <= pos_in;
      end
   end

   // window ring: shifts on a new base, rotates once around during the sweep
   assign new_code = pwmscan_pkg::base_code(req_seq_char);
   assign tap      = ring[MAX_MOTIF_LEN-1];

   for (genvar k = 0; k < MAX_MOTIF_LEN; k++) begin : g_ring
      pwmscan_pkg::cell_ctl_type  cctl;
      pwmscan_pkg::base_code_type prev;
      if (k == 0) begin : g_head
         assign prev       = char_accept ? new_code : ring[MAX_MOTIF_LEN-1];
         assign cctl.clear = 1'b0;
      end else begin : g_body
         assign prev       = ring[k-1];
         assign cctl.clear = char_accept && req_seq_start;
      end
      assign cctl.advance = char_accept || (state_ff == ST_SWEEP);
      pwmscan_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cctl),
         .code_in  (prev),
         .code_out (ring[k])
      );
   end

   // weight load with saturation to the table width
   always_comb begin
      weight_wide = 33'(req_weight_value);
      if (weight_wide > W_MAX) begin
         weight_clamped = W_MAX;
      end else if (weight_wide < W_MIN) begin
         weight_clamped = W_MIN;
      end else begin
         weight_clamped = weight_wide;
      end
      weight_sat = WEIGHT_BITS'(weight_clamped);
   end

   // step s of the sweep sees window index MAX-1-s, motif offset s+len-MAX
   assign in_window = (32'(step_ff) + 32'(act_len)) >= 32'(MAX_MOTIF_LEN);
   assign rd_offset = OFF_W'(32'(step_ff) + 32'(act_len) - 32'(MAX_MOTIF_LEN));
   assign rd_addr   = {rd_offset, tap[1:0]};
   assign wr_addr   = {OFF_W'(req_weight_offset), req_weight_base};

   assign score_ctl.clear = char_accept;
   assign score_ctl.rd_en = (state_ff == ST_SWEEP) && in_window &&
                            (tap != pwmscan_pkg::CODE_NONE);
   assign score_ctl.wr_en = weight_accept &&
                            (32'(req_weight_offset) < 32'(MAX_MOTIF_LEN));

   pwmscan_score #(
      .MAX_MOTIF_LEN (MAX_MOTIF_LEN),
      .WEIGHT_BITS   (WEIGHT_BITS)
   ) u_score (
      .clock   (clock),
      .reset   (reset),
      .ctl     (score_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (weight_sat),
      .score   (score)
   );

   always_comb begin
      score_wide     = CMP_W'(score);
      threshold_wide = CMP_W'(threshold_ff);
      hit            = score_wide > threshold_wide;
      if (score_wide > S_MAX) begin
         score_sat = S_MAX;
      end else if (score_wide < S_MIN) begin
         score_sat = S_MIN;
      end else begin
         score_sat = score_wide;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (char_accept && window_full) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!hit) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pos_ff   <= pos_ff;
         rsp_score_ff <= pwmscan_pkg::SCORE_W'(score_sat);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_position = rsp_pos_ff;
   assign rsp_hit_score    = rsp_score_ff;

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && step_ff == STEP_LAST) |=> (state_ff == ST_FLUSH))
      else $error("sweep did not end after the last step");

   a_read_in_sweep: assert property (@(posedge clock) disable iff (reset)
      score_ctl.rd_en |-> (state_ff == ST_SWEEP) && !score_ctl.wr_en)
      else $error("weight read outside the sweep or alongside a write");

   a_hit_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result posted outside the finish step");

   a_finish_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ($past(state_ff) == ST_FLUSH ||
                                   $past(state_ff) == ST_FINISH))
      else $error("finish reached without flushing the last read");

endmodule

// ----- design/pwmscan_cell.sv -----
module pwmscan_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pwmscan_pkg::cell_ctl_type ctl,
   input  pwmscan_pkg::base_code_type code_in,
   output pwmscan_pkg::base_code_type code_out
);

   pwmscan_pkg::base_code_type code_ff;
   pwmscan_pkg::base_code_type code_in_next;

   always_comb begin
      code_in_next = code_ff;
      if (ctl.advance) begin
         code_in_next = ctl.clear ? pwmscan_pkg::CODE_NONE : code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= pwmscan_pkg::CODE_NONE;
      end else begin
         code_ff <= code_in_next;
      end
   end

   assign code_out = code_ff;

endmodule

// ----- design/pwmscan_score.sv -----
module pwmscan_score #(
   parameter int MAX_MOTIF_LEN = pwmscan_pkg::MAX_MOTIF_LEN_DEF,
   parameter int WEIGHT_BITS   = pwmscan_pkg::WEIGHT_BITS_DEF,
   localparam int OFF_W  = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1,
   localparam int ADDR_W = OFF_W + 2,
   localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_MOTIF_LEN + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pwmscan_pkg::score_ctl_type    ctl,
   input  logic [ADDR_W-1:0]             rd_addr,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [WEIGHT_BITS-1:0] wr_data,
   output logic signed [SUM_W-1:0]       score
);

   localparam int DEPTH = MAX_MOTIF_LEN * 4;

   logic signed [WEIGHT_BITS-1:0] weight_mem [DEPTH];
   logic signed [WEIGHT_BITS-1:0] rdata_ff;
   logic                          rd_valid_ff;
   logic signed [SUM_W-1:0]       acc_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (rd_valid_ff) begin
         acc_ff <= acc_ff + SUM_W'(rdata_ff);
      end
   end

   assign score = acc_ff;

endmodule

// ----- bench/pwm_motif_window_scanner_tb.sv -----
`timescale 1ns / 1ps

module pwm_motif_window_scanner_tb;

   localparam int MOTIF_MAX     = pwmscan_pkg::MAX_MOTIF_LEN_DEF;
   localparam int SETTLE_CYCLES = 2 * (MOTIF_MAX + 3);
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 150;
   localparam int PHASES        = 10;
   localparam int HOLD_CYCLES   = 400;

   localparam logic KIND_WEIGHT = pwmscan_pkg::KIND_WEIGHT;
   localparam logic KIND_CHAR   = pwmscan_pkg::KIND_CHAR;

   localparam pwmscan_pkg::base_code_type CODE_A    = pwmscan_pkg::CODE_A;
   localparam pwmscan_pkg::base_code_type CODE_C    = pwmscan_pkg::CODE_C;
   localparam pwmscan_pkg::base_code_type CODE_G    = pwmscan_pkg::CODE_G;
   localparam pwmscan_pkg::base_code_type CODE_T    = pwmscan_pkg::CODE_T;
   localparam pwmscan_pkg::base_code_type CODE_NONE = pwmscan_pkg::CODE_NONE;

   localparam logic [7:0] CHAR_A = pwmscan_pkg::CHAR_A;
   localparam logic [7:0] CHAR_C = pwmscan_pkg::CHAR_C;
   localparam logic [7:0] CHAR_G = pwmscan_pkg::CHAR_G;
   localparam logic [7:0] CHAR_T = pwmscan_pkg::CHAR_T;

   typedef struct packed {
      logic                kind;
      logic [4:0]          weight_offset;
      logic [1:0]          weight_base;
      logic signed [15:0]  weight_value;
      logic [7:0]          seq_char;
      logic                seq_start;
   } scan_item_type;

   typedef struct packed {
      logic [15:0]         position;
      logic signed [20:0]  score;
   } hit_type;

   // typed rows carry their own expectation, the rest go through the predictor
   typedef struct packed {
      scan_item_type       item;
      logic                typed;
      logic                hit;
      logic [15:0]         position;
      logic signed [20:0]  score;
   } dir_row_type;

   localparam int DIR_ROWS = 22;

   // run with motif_length 1 and threshold 0, so only offset 0 scores
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_A), 16'sh7FFF, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_A, 1'b1}, 1'b1, 1'b1, 16'd1, 21'sd32767},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_C), 16'sh8000, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_C, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      // non-ACGT byte scores zero, which does not beat a zero threshold
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_G), 16'sh0001, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_G, 1'b0}, 1'b1, 1'b1, 16'd4, 21'sd1},
      // lower case does not score
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, 8'h67, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_T), 16'sh0100, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      // weight item ignores its char and start fields
      '{'{KIND_WEIGHT, 5'd31, 2'(CODE_T), 16'sh8000, CHAR_A, 1'b1}, 1'b1, 1'b0, 16'd0, 21'sd0},
      // char item ignores its weight fields
      '{'{KIND_CHAR, 5'd31, 2'd3, 16'sh7FFF, CHAR_T, 1'b0}, 1'b1, 1'b1, 16'd6, 21'sd256},
      '{'{KIND_CHAR, 5'd31, 2'd3, 16'sh8000, CHAR_T, 1'b1}, 1'b1, 1'b1, 16'd1, 21'sd256},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, 8'hFF, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_A), 16'shFFFF, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_A, 1'b0}, 1'b1, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_C), 16'sh00FF, 8'h00, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_C, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_A, 1'b1}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_WEIGHT, 5'd0, 2'(CODE_G), 16'sh8000, 8'h00, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_G, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, CHAR_T, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0},
      '{'{KIND_CHAR, 5'd0, 2'd0, 16'sh0000, 8'h80, 1'b0}, 1'b0, 1'b0, 16'd0, 21'sd0}
   };

   localparam int PHASE_LEN [PHASES] = '{1, 32, 0, 63, 7, 32, 16, 2, 5, 20};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_kind;
   logic [4:0]             req_weight_offset;
   logic [1:0]             req_weight_base;
   logic signed [15:0]     req_weight_value;
   logic [7:0]             req_seq_char;
   logic                   req_seq_start;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [pwmscan_pkg::HIT_POS_W-1:0]   rsp_hit_position;
   logic signed [pwmscan_pkg::SCORE_W-1:0] rsp_hit_score;
   logic                   csr_write_enable;
   logic                   csr_index;
   logic [pwmscan_pkg::SCORE_W-1:0]     csr_write_data;

   // scanner state as the predictor sees it
   logic signed [15:0]     pwm_weights [MOTIF_MAX*4];
   pwmscan_pkg::base_code_type window_codes [MOTIF_MAX];
   logic [15:0]            seq_count;
   logic [5:0]             cfg_motif_len;
   int                     cfg_threshold;

   hit_type                expected_hits [$];
   hit_type                want_hit;
   int                     error_count = 0;
   int                     quiet_cycles = 0;
   int                     req_idle_pct = 0;
   int                     rsp_stall_pct = 0;
   int                     rsp_hold_cycles = 0;

   pwm_motif_window_scanner uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_weight_offset (req_weight_offset),
      .req_weight_base   (req_weight_base),
      .req_weight_value  (req_weight_value),
      .req_seq_char      (req_seq_char),
      .req_seq_start     (req_seq_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit_position  (rsp_hit_position),
      .rsp_hit_score     (rsp_hit_score),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit predict_hit(input scan_item_type it, output hit_type res);
      int i;
      int span;
      int sum;
      pwmscan_pkg::base_code_type code;
      res = '0;
      if (it.kind == KIND_WEIGHT) begin
         pwm_weights[{it.weight_offset, it.weight_base}] = it.weight_value;
         return 1'b0;
      end
      if (it.seq_start) begin
         for (i = 0; i < MOTIF_MAX; i++) window_codes[i] = CODE_NONE;
         seq_count = '0;
      end
      for (i = MOTIF_MAX - 1; i > 0; i--) window_codes[i] = window_codes[i-1];
      case (it.seq_char)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_NONE;
      endcase
      window_codes[0] = code;
      if (seq_count != '1) seq_count++;
      span = (cfg_motif_len == 0) ? 1 :
             (cfg_motif_len > MOTIF_MAX) ? MOTIF_MAX : int'(cfg_motif_len);
      if (int'(seq_count) < span) return 1'b0;
      sum = 0;
      // window slot span-1 is the oldest base and pairs with offset 0
      for (i = 0; i < span; i++) begin
         code = window_codes[span-1-i];
         if (code != CODE_NONE) sum += pwm_weights[i*4 + int'(code)];
      end
      if (sum <= cfg_threshold) return 1'b0;
      res.position = (seq_count == '1) ? '1 : 16'(int'(seq_count) - span + 1);
      if (sum > pwmscan_pkg::SCORE_MAX) sum = pwmscan_pkg::SCORE_MAX;
      if (sum < pwmscan_pkg::SCORE_MIN) sum = pwmscan_pkg::SCORE_MIN;
      res.score = 21'(sum);
      return 1'b1;
   endfunction

   function automatic scan_item_type random_item();
      scan_item_type it;
      it.kind          = ($urandom_range(0, 99) < 8) ? KIND_WEIGHT : KIND_CHAR;
      it.weight_offset = 5'($urandom);
      it.weight_base   = 2'($urandom);
      it.weight_value  = 16'($urandom);
      if ($urandom_range(0, 99) < 85) begin
         case ($urandom_range(0, 3))
            0:       it.seq_char = CHAR_A;
            1:       it.seq_char = CHAR_C;
            2:       it.seq_char = CHAR_G;
            default: it.seq_char = CHAR_T;
         endcase
      end else begin
         it.seq_char = 8'($urandom);
      end
      it.seq_start = ($urandom_range(0, 99) < 2);
      return it;
   endfunction

   task automatic send_item(input scan_item_type it, input bit typed, input bit typed_hit,
                            input hit_type typed_res);
      hit_type res;
      bit got;
      req_valid         <= 1'b1;
      req_kind          <= it.kind;
      req_weight_offset <= it.weight_offset;
      req_weight_base   <= it.weight_base;
      req_weight_value  <= it.weight_value;
      req_seq_char      <= it.seq_char;
      req_seq_start     <= it.seq_start;
      do @(posedge clock); while (req_stall);
      got = predict_hit(it, res);
      if (typed) begin
         got = typed_hit;
         res = typed_res;
      end
      if (got) expected_hits.insert(expected_hits.size(), res);
   endtask

   // hold the input off until every hit is in, then let the scorer finish
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input int motif_len, input int threshold);
      csr_write_enable <= 1'b1;
      csr_index        <= pwmscan_pkg::CSR_MOTIF_LENGTH;
      csr_write_data   <= pwmscan_pkg::SCORE_W'(motif_len);
      @(posedge clock);
      csr_index        <= pwmscan_pkg::CSR_HIT_THRESHOLD;
      csr_write_data   <= pwmscan_pkg::SCORE_W'(threshold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_motif_len = 6'(motif_len);
      cfg_threshold = threshold;
   endtask

   // receiver: random stall, or one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: hit with none expected: pos %0d score %0d", $time,
                     rsp_hit_position, rsp_hit_score);
            error_count++;
         end else begin
            want_hit = expected_hits.pop_front();
            if (rsp_hit_position !== want_hit.position) begin
               $display("%0t: hit_position expected %0d actual %0d", $time,
                        want_hit.position, rsp_hit_position);
               error_count++;
            end
            if (rsp_hit_score !== want_hit.score) begin
               $display("%0t: hit_score expected %0d actual %0d", $time,
                        want_hit.score, rsp_hit_score);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int n;
      int phase;
      int span;
      int threshold;
      scan_item_type it;
      hit_type row_hit;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_kind          <= KIND_WEIGHT;
      req_weight_offset <= '0;
      req_weight_base   <= '0;
      req_weight_value  <= '0;
      req_seq_char      <= '0;
      req_seq_start     <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= pwmscan_pkg::CSR_MOTIF_LENGTH;
      csr_write_data    <= '0;
      for (n = 0; n < MOTIF_MAX; n++) window_codes[n] = CODE_NONE;
      seq_count     = '0;
      cfg_motif_len = 6'd32;
      cfg_threshold = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every table entry gets written before any window is scored
      for (n = 0; n < MOTIF_MAX * 4; n++) begin
         it               = random_item();
         it.kind          = KIND_WEIGHT;
         it.weight_offset = 5'(n / 4);
         it.weight_base   = 2'(n % 4);
         send_item(it, 1'b0, 1'b0, '0);
      end
      drain();

      set_config(1, 0);
      for (n = 0; n < DIR_ROWS; n++) begin
         row_hit = '{DIRECTED[n].position, DIRECTED[n].score};
         send_item(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].hit, row_hit);
      end
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         span = (PHASE_LEN[phase] == 0) ? 1 :
                (PHASE_LEN[phase] > MOTIF_MAX) ? MOTIF_MAX : PHASE_LEN[phase];
         case (phase)
            2, 4:    threshold = pwmscan_pkg::SCORE_MIN;
            3:       threshold = pwmscan_pkg::SCORE_MAX;
            default: threshold = int'($urandom_range(0, 12000 * span)) - 6000 * span;
         endcase
         set_config(PHASE_LEN[phase], threshold);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin req_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         // every window hits here, so a long hold-off backs up into the input
         if (phase == 4) rsp_hold_cycles = HOLD_CYCLES;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            while ($urandom_range(0, 99) < req_idle_pct) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
            send_item(random_item(), 1'b0, 1'b0, '0);
         end
         drain();
      end

      if (error_count == 0 && expected_hits.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
